// ----- rtl/core/complex_arithmetic_unit_macros.svh -----
// Assertion helpers shared by the checkers of the complex arithmetic unit.
// Every macro samples on the rising edge of clk and is off while arst_n is low.
`ifndef COMPLEX_ARITHMETIC_UNIT_MACROS_SVH
`define COMPLEX_ARITHMETIC_UNIT_MACROS_SVH

// The consequence must hold in the same cycle as the antecedent.
`define CAU_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("complex arithmetic unit check failed");

// The consequence must hold in the cycle after the antecedent.
`define CAU_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("complex arithmetic unit check failed");

`endif

// ----- rtl/core/cau_pkg.sv -----
`default_nettype none

package cau_pkg;

	localparam int DATA_WIDTH = 32;
	localparam int FRAC_BITS  = 16;
	localparam int PROD_W     = 2 * DATA_WIDTH;
	localparam int N_CELLS    = DATA_WIDTH;
	localparam int SQ_REM_W   = DATA_WIDTH + 3;

	typedef enum logic [2:0] {
		CMD_ADD = 3'd0,
		CMD_SUB = 3'd1,
		CMD_MUL = 3'd2,
		CMD_DIV = 3'd3,
		CMD_NEG = 3'd4,
		CMD_MAG = 3'd5,
		CMD_EQ  = 3'd6
	} cmd_t;

	localparam logic [1:0] ST_OK  = 2'd0;
	localparam logic [1:0] ST_SAT = 2'd1;
	localparam logic [1:0] ST_DZ  = 2'd2;

	// One part of the result in sign-magnitude form. For a division, rem is
	// the partial remainder and quo shifts dividend bits out and quotient bits in.
	typedef struct packed {
		logic                  neg;
		logic [PROD_W-1:0]     rem;
		logic [DATA_WIDTH-1:0] quo;
	} lane_t;

	typedef struct packed {
		logic                  vld;
		cmd_t                  cmd;
		logic                  equal;
		logic                  dz;
		logic                  ovf_re;
		logic                  ovf_im;
		lane_t                 re;
		lane_t                 im;
		logic [PROD_W-1:0]     den;
		logic [PROD_W-1:0]     sq_v;
		logic [SQ_REM_W-1:0]   sq_rem;
		logic [DATA_WIDTH-1:0] sq_root;
	} cell_t;

	typedef struct packed {
		logic signed [DATA_WIDTH-1:0] r_re;
		logic signed [DATA_WIDTH-1:0] r_im;
		logic                         equal;
		logic [1:0]                   status;
	} res_t;

endpackage

`default_nettype wire

// ----- rtl/core/cau_if.sv -----
`default_nettype none

interface cau_req_if;
	logic                                 valid;
	logic                                 ready;
	logic [2:0]                           command;
	logic signed [cau_pkg::DATA_WIDTH-1:0] a_re;
	logic signed [cau_pkg::DATA_WIDTH-1:0] a_im;
	logic signed [cau_pkg::DATA_WIDTH-1:0] b_re;
	logic signed [cau_pkg::DATA_WIDTH-1:0] b_im;

	modport source (output valid, command, a_re, a_im, b_re, b_im, input ready);
	modport sink (input valid, command, a_re, a_im, b_re, b_im, output ready);
endinterface

interface cau_rsp_if;
	logic                                 valid;
	logic                                 ready;
	logic signed [cau_pkg::DATA_WIDTH-1:0] r_re;
	logic signed [cau_pkg::DATA_WIDTH-1:0] r_im;
	logic                                 equal;
	logic [1:0]                           status;

	modport source (output valid, r_re, r_im, equal, status, input ready);
	modport sink (input valid, r_re, r_im, equal, status, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/cau_front.sv -----
`default_nettype none

// Operand capture, products, sums, sign-magnitude and divider setup.
module cau_front (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  en,
	input  wire logic                                  in_vld,
	input  wire logic [2:0]                            command,
	input  wire logic signed [cau_pkg::DATA_WIDTH-1:0] a_re,
	input  wire logic signed [cau_pkg::DATA_WIDTH-1:0] a_im,
	input  wire logic signed [cau_pkg::DATA_WIDTH-1:0] b_re,
	input  wire logic signed [cau_pkg::DATA_WIDTH-1:0] b_im,
	output cau_pkg::cell_t                             cell_o
);

	localparam int DW = cau_pkg::DATA_WIDTH;
	localparam int PW = cau_pkg::PROD_W;
	localparam int FB = cau_pkg::FRAC_BITS;

	// Stage 1: operands.
	logic                 vld_s1;
	cau_pkg::cmd_t        cmd_s1;
	logic signed [DW-1:0] ar_s1, ai_s1, br_s1, bi_s1;

	// Stage 2: products, short sums, equality.
	logic                 vld_s2;
	cau_pkg::cmd_t        cmd_s2;
	logic signed [PW-1:0] p0_s2, p1_s2, p2_s2, p3_s2, p4_s2, p5_s2;
	logic signed [DW:0]   as_re_s2, as_im_s2;
	logic                 eq_s2;
	logic signed [DW-1:0] mx_a, mx_b;
	logic signed [DW:0]   as_re_c, as_im_c;

	// Stage 3: wide sums.
	logic                 vld_s3;
	cau_pkg::cmd_t        cmd_s3;
	logic signed [PW:0]   x_re_s3, x_im_s3;
	logic [PW-1:0]        den_s3;
	logic                 eq_s3;
	logic signed [PW:0]   x_re_c, x_im_c;

	// Stage 4: sign-magnitude.
	logic                 vld_s4;
	cau_pkg::cmd_t        cmd_s4;
	logic                 neg_re_s4, neg_im_s4;
	logic [PW-1:0]        mag_re_s4, mag_im_s4;
	logic [PW-1:0]        den_s4;
	logic                 eq_s4;
	logic [PW-1:0]        abs_re, abs_im;

	// Stage 5: entry to the cell chain.
	logic                 vld_s5;
	cau_pkg::cell_t       pay_s5;
	cau_pkg::cell_t       nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cmd_s1 <= cau_pkg::cmd_t'(command);
			ar_s1  <= a_re;
			ai_s1  <= a_im;
			br_s1  <= b_re;
			bi_s1  <= b_im;
		end
	end

	// The magnitude command reuses the two square multipliers of the divisor.
	assign mx_a = (cmd_s1 == cau_pkg::CMD_MAG) ? ar_s1 : br_s1;
	assign mx_b = (cmd_s1 == cau_pkg::CMD_MAG) ? ai_s1 : bi_s1;

	always_comb begin
		case (cmd_s1)
			cau_pkg::CMD_ADD: begin
				as_re_c = (DW+1)'(ar_s1) + (DW+1)'(br_s1);
				as_im_c = (DW+1)'(ai_s1) + (DW+1)'(bi_s1);
			end
			cau_pkg::CMD_SUB: begin
				as_re_c = (DW+1)'(ar_s1) - (DW+1)'(br_s1);
				as_im_c = (DW+1)'(ai_s1) - (DW+1)'(bi_s1);
			end
			cau_pkg::CMD_NEG: begin
				as_re_c = -(DW+1)'(ar_s1);
				as_im_c = -(DW+1)'(ai_s1);
			end
			default: begin
				as_re_c = '0;
				as_im_c = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cmd_s2   <= cmd_s1;
			p0_s2    <= ar_s1 * br_s1;
			p1_s2    <= ai_s1 * bi_s1;
			p2_s2    <= ar_s1 * bi_s1;
			p3_s2    <= ai_s1 * br_s1;
			p4_s2    <= mx_a * mx_a;
			p5_s2    <= mx_b * mx_b;
			as_re_s2 <= as_re_c;
			as_im_s2 <= as_im_c;
			eq_s2    <= (cmd_s1 == cau_pkg::CMD_EQ) && (ar_s1 == br_s1) && (ai_s1 == bi_s1);
		end
	end

	always_comb begin
		case (cmd_s2)
			cau_pkg::CMD_ADD, cau_pkg::CMD_SUB, cau_pkg::CMD_NEG: begin
				x_re_c = (PW+1)'(as_re_s2);
				x_im_c = (PW+1)'(as_im_s2);
			end
			cau_pkg::CMD_MUL: begin
				x_re_c = (PW+1)'(p0_s2) - (PW+1)'(p1_s2);
				x_im_c = (PW+1)'(p2_s2) + (PW+1)'(p3_s2);
			end
			cau_pkg::CMD_DIV: begin
				x_re_c = (PW+1)'(p0_s2) + (PW+1)'(p1_s2);
				x_im_c = (PW+1)'(p3_s2) - (PW+1)'(p2_s2);
			end
			default: begin
				x_re_c = '0;
				x_im_c = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cmd_s3  <= cmd_s2;
			x_re_s3 <= x_re_c;
			x_im_s3 <= x_im_c;
			den_s3  <= $unsigned(p4_s2) + $unsigned(p5_s2);
			eq_s3   <= eq_s2;
		end
	end

	assign abs_re = x_re_s3[PW] ? PW'(-x_re_s3) : PW'(x_re_s3);
	assign abs_im = x_im_s3[PW] ? PW'(-x_im_s3) : PW'(x_im_s3);

	always_ff @(posedge clk) begin
		if (en) begin
			cmd_s4    <= cmd_s3;
			neg_re_s4 <= x_re_s3[PW];
			neg_im_s4 <= x_im_s3[PW];
			// A product drops its fraction bits by truncating the magnitude.
			mag_re_s4 <= (cmd_s3 == cau_pkg::CMD_MUL) ? (abs_re >> FB) : abs_re;
			mag_im_s4 <= (cmd_s3 == cau_pkg::CMD_MUL) ? (abs_im >> FB) : abs_im;
			den_s4    <= den_s3;
			eq_s4     <= eq_s3;
		end
	end

	// The dividend is the magnitude scaled by two to the fraction bits. Its upper
	// part starts as the remainder; the quotient fits only when that part is
	// below the divisor.
	always_comb begin
		nxt        = '0;
		nxt.cmd    = cmd_s4;
		nxt.equal  = eq_s4;
		nxt.dz     = (den_s4 == '0);
		nxt.den    = den_s4;
		nxt.sq_v   = den_s4;
		nxt.re.neg = neg_re_s4;
		nxt.im.neg = neg_im_s4;
		if (cmd_s4 == cau_pkg::CMD_DIV) begin
			nxt.re.rem = mag_re_s4 >> (DW - FB);
			nxt.im.rem = mag_im_s4 >> (DW - FB);
			nxt.re.quo = DW'(mag_re_s4 << FB);
			nxt.im.quo = DW'(mag_im_s4 << FB);
			nxt.ovf_re = (mag_re_s4 >> (DW - FB)) >= den_s4;
			nxt.ovf_im = (mag_im_s4 >> (DW - FB)) >= den_s4;
		end else begin
			nxt.re.rem = mag_re_s4;
			nxt.im.rem = mag_im_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pay_s5 <= nxt;
		end
	end

	always_comb begin
		cell_o     = pay_s5;
		cell_o.vld = vld_s5;
	end

endmodule

`default_nettype wire

// ----- rtl/core/cau_cell.sv -----
`default_nettype none

// One step of the chain: a quotient bit for both parts of a division, or one
// root bit of a magnitude. Other commands pass through unchanged.
module cau_cell (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      en,
	input  cau_pkg::cell_t d,
	output cau_pkg::cell_t q
);

	localparam int DW = cau_pkg::DATA_WIDTH;
	localparam int PW = cau_pkg::PROD_W;
	localparam int SW = cau_pkg::SQ_REM_W;

	function automatic cau_pkg::lane_t div_step(cau_pkg::lane_t l, logic [PW-1:0] den);
		logic [PW:0]    r2;
		cau_pkg::lane_t o;
		begin
			r2 = {l.rem, l.quo[DW-1]};
			o  = l;
			if (r2 >= {1'b0, den}) begin
				o.rem = PW'(r2 - {1'b0, den});
				o.quo = {l.quo[DW-2:0], 1'b1};
			end else begin
				o.rem = r2[PW-1:0];
				o.quo = {l.quo[DW-2:0], 1'b0};
			end
			return o;
		end
	endfunction

	logic [SW-1:0]  rem_n;
	logic [SW-1:0]  trial;
	logic           vld_q;
	cau_pkg::cell_t nxt;
	cau_pkg::cell_t pay_q;

	assign rem_n = {d.sq_rem[SW-3:0], d.sq_v[PW-1:PW-2]};
	assign trial = SW'({d.sq_root, 2'b01});

	always_comb begin
		nxt = d;
		case (d.cmd)
			cau_pkg::CMD_DIV: begin
				nxt.re = div_step(d.re, d.den);
				nxt.im = div_step(d.im, d.den);
			end
			cau_pkg::CMD_MAG: begin
				nxt.sq_v = {d.sq_v[PW-3:0], 2'b00};
				if (rem_n >= trial) begin
					nxt.sq_rem  = rem_n - trial;
					nxt.sq_root = {d.sq_root[DW-2:0], 1'b1};
				end else begin
					nxt.sq_rem  = rem_n;
					nxt.sq_root = {d.sq_root[DW-2:0], 1'b0};
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (en) begin
			vld_q <= d.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pay_q <= nxt;
		end
	end

	always_comb begin
		q     = pay_q;
		q.vld = vld_q;
	end

endmodule

`default_nettype wire

// ----- rtl/core/cau_back.sv -----
`default_nettype none

// Saturation, status, output register and skid register.
module cau_back (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  cau_pkg::cell_t last,
	input  wire logic      rsp_ready,
	output logic           en,
	output logic           rsp_valid,
	output cau_pkg::res_t  rsp_data
);

	localparam int DW = cau_pkg::DATA_WIDTH;
	localparam int PW = cau_pkg::PROD_W;
	localparam logic [PW-1:0] MAXP = {{(PW-DW+1){1'b0}}, {(DW-1){1'b1}}};

	// Returns the clipped flag above the clipped value.
	function automatic logic [DW:0] saturate(logic neg, logic [PW-1:0] mag);
		logic [DW-1:0] v;
		begin
			v = '0;
			if (mag == '0) begin
				return '0;
			end else if (!neg) begin
				if (mag > MAXP) begin
					return {1'b1, MAXP[DW-1:0]};
				end
				return {1'b0, mag[DW-1:0]};
			end else begin
				if (mag > MAXP + 1'b1) begin
					return {1'b1, 1'b1, {(DW-1){1'b0}}};
				end
				v = -mag[DW-1:0];
				return {1'b0, v};
			end
		end
	endfunction

	logic [PW-1:0]  mre, mim;
	logic [DW:0]    sre, sim;
	cau_pkg::res_t  fin;
	cau_pkg::res_t  out_q, skid_q;
	logic           out_vld_q, skid_full_q;

	always_comb begin
		mre = last.re.rem;
		mim = last.im.rem;
		case (last.cmd)
			cau_pkg::CMD_DIV: begin
				mre = last.ovf_re ? '1 : PW'(last.re.quo);
				mim = last.ovf_im ? '1 : PW'(last.im.quo);
			end
			cau_pkg::CMD_MAG: begin
				mre = PW'(last.sq_root);
			end
			default: begin
			end
		endcase
		sre = saturate(last.re.neg, mre);
		sim = saturate(last.im.neg, mim);
		fin.r_re   = sre[DW-1:0];
		fin.r_im   = sim[DW-1:0];
		fin.equal  = last.equal;
		fin.status = (sre[DW] || sim[DW]) ? cau_pkg::ST_SAT : cau_pkg::ST_OK;
		if ((last.cmd == cau_pkg::CMD_DIV) && last.dz) begin
			fin.r_re   = '0;
			fin.r_im   = '0;
			fin.status = cau_pkg::ST_DZ;
		end
	end

	assign en        = !skid_full_q;
	assign rsp_valid = out_vld_q;
	assign rsp_data  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q   <= 1'b0;
			skid_full_q <= 1'b0;
		end else if (skid_full_q) begin
			if (rsp_ready) begin
				skid_full_q <= 1'b0;
			end
		end else if (out_vld_q && !rsp_ready) begin
			if (last.vld) begin
				skid_full_q <= 1'b1;
			end
		end else begin
			out_vld_q <= last.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_full_q) begin
			if (rsp_ready) begin
				out_q <= skid_q;
			end
		end else if (out_vld_q && !rsp_ready) begin
			if (last.vld) begin
				skid_q <= fin;
			end
		end else begin
			out_q <= fin;
		end
	end

endmodule

`default_nettype wire

// ----- rtl/core/complex_arithmetic_unit.sv -----
`default_nettype none

// Complex arithmetic unit on signed Q16.16 operands. Each request transfer
// carries a command and two complex numbers a and b; each brings exactly one
// response transfer, in order: sum, difference, product, quotient, negation of
// a, magnitude of a (in r_re), or an equality test (in equal). Every result
// part saturates, with status 1; a division by zero gives zero and status 2.
// The unit takes one request every cycle while ready is high; each result passes
// through five front stages (operand capture, the multipliers, the wide
// sums, the sign-magnitude conversion, divider setup), a chain of 32 cells
// that each produce one quotient bit or one square-root bit, and the output
// register. A skid register behind the output keeps the pipeline moving for
// one more transfer while a result waits; ready drops only when both hold one.
module complex_arithmetic_unit (
	input  wire logic clk,
	input  wire logic arst_n,
	cau_req_if.sink   req,
	cau_rsp_if.source rsp
);

	logic           en;
	cau_pkg::res_t  res;
	cau_pkg::cell_t chain [0:cau_pkg::N_CELLS];

	assign req.ready = en;

	cau_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.in_vld (req.valid),
		.command(req.command),
		.a_re   (req.a_re),
		.a_im   (req.a_im),
		.b_re   (req.b_re),
		.b_im   (req.b_im),
		.cell_o (chain[0])
	);

	// Each cell hands its item to the next one in every cycle that the
	// pipeline advances.
	for (genvar g = 0; g < cau_pkg::N_CELLS; g++) begin : g_cell
		cau_cell u_cell (
			.clk   (clk),
			.arst_n(arst_n),
			.en    (en),
			.d     (chain[g]),
			.q     (chain[g+1])
		);
	end

	cau_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.last     (chain[cau_pkg::N_CELLS]),
		.rsp_ready(rsp.ready),
		.en       (en),
		.rsp_valid(rsp.valid),
		.rsp_data (res)
	);

	assign rsp.r_re   = res.r_re;
	assign rsp.r_im   = res.r_im;
	assign rsp.equal  = res.equal;
	assign rsp.status = res.status;

endmodule

`default_nettype wire

// ----- rtl/core/cau_checker.sv -----
`default_nettype none

`include "complex_arithmetic_unit_macros.svh"

module cau_checker (
	input wire logic                                  clk,
	input wire logic                                  arst_n,
	input wire logic                                  rsp_valid,
	input wire logic                                  rsp_ready,
	input wire logic signed [cau_pkg::DATA_WIDTH-1:0] r_re,
	input wire logic signed [cau_pkg::DATA_WIDTH-1:0] r_im,
	input wire logic                                  equal,
	input wire logic [1:0]                            status
);

	`CAU_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid)
	`CAU_ASSERT_NEXT(a_rsp_stable, rsp_valid && !rsp_ready, $stable(r_re) && $stable(r_im))
	`CAU_ASSERT_NOW(a_equal_clean, rsp_valid && equal, r_re == '0 && r_im == '0 && status == cau_pkg::ST_OK)
	`CAU_ASSERT_NOW(a_dz_clean, rsp_valid && status == cau_pkg::ST_DZ, r_re == '0 && r_im == '0 && !equal)

endmodule

bind complex_arithmetic_unit cau_checker u_cau_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.rsp_valid(rsp.valid),
	.rsp_ready(rsp.ready),
	.r_re     (rsp.r_re),
	.r_im     (rsp.r_im),
	.equal    (rsp.equal),
	.status   (rsp.status)
);

`default_nettype wire
